// File: rtl/core/pisf_pkg.sv
package pisf_pkg;

  localparam int PARTICLES = 256;
  localparam int IDX_W     = $clog2(PARTICLES);

  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 33;
  localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

  // shared multiplier schedule
  localparam logic [3:0] MS_AXX = 4'd0;
  localparam logic [3:0] MS_AYY = 4'd1;
  localparam logic [3:0] MS_CA  = 4'd2;
  localparam logic [3:0] MS_MBX = 4'd3;
  localparam logic [3:0] MS_MBY = 4'd4;
  localparam logic [3:0] MS_DLO = 4'd5;
  localparam logic [3:0] MS_DHI = 4'd6;
  localparam logic [3:0] MS_NX0 = 4'd7;
  localparam logic [3:0] MS_NX1 = 4'd8;
  localparam logic [3:0] MS_NX2 = 4'd9;
  localparam logic [3:0] MS_NX3 = 4'd10;
  localparam logic [3:0] MS_NY0 = 4'd11;
  localparam logic [3:0] MS_NY1 = 4'd12;
  localparam logic [3:0] MS_NY2 = 4'd13;
  localparam logic [3:0] MS_NY3 = 4'd14;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         first_index;
    logic [7:0]         second_index;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [31:0]        first_mass;
    logic [31:0]        second_mass;
    logic signed [31:0] first_charge;
    logic signed [31:0] second_charge;
  } pisf_in_t;

  typedef struct packed {
    logic signed [31:0] pair_force_x;
    logic signed [31:0] pair_force_y;
    logic signed [31:0] first_total_x;
    logic signed [31:0] first_total_y;
    logic signed [31:0] second_total_x;
    logic signed [31:0] second_total_y;
    logic               coincident;
  } pisf_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RD1,
    OP_WR1,
    OP_RD2,
    OP_WR2
  } pisf_op_t;

  typedef struct packed {
    pisf_op_t   op;
    logic [3:0] step;
  } pisf_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_SQI,
    ST_SQRT,
    ST_MUL2,
    ST_DRAIN,
    ST_DVI,
    ST_DIV,
    ST_RD1,
    ST_WR1,
    ST_RD2,
    ST_WR2
  } pisf_state_t;

  function automatic logic [31:0] sat32(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pisf_ram.sv
module pisf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/pisf_ctrl.sv
module pisf_ctrl import pisf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output pisf_cmd_t cmd
);

  pisf_state_t      state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    cmd.step   = cnt[3:0];
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = ST_MUL1;
          cnt_next   = CNT_W'(MS_AXX);
        end
      end
      ST_MUL1: begin
        cmd.op = OP_MUL;
        if (cnt[3:0] == MS_MBY) begin
          state_next = ST_SQI;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SQI: begin
        cmd.op     = OP_SQRT_INIT;
        state_next = ST_SQRT;
        cnt_next   = '0;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = ST_MUL2;
          cnt_next   = CNT_W'(MS_DLO);
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_MUL2: begin
        cmd.op = OP_MUL;
        if (cnt[3:0] == MS_NY3) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: state_next = ST_DVI;  // last product lands in its accumulator
      ST_DVI: begin
        cmd.op     = OP_DIV_INIT;
        state_next = ST_DIV;
        cnt_next   = '0;
      end
      ST_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_RD1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_RD1: begin
        cmd.op     = OP_RD1;
        state_next = ST_WR1;
      end
      ST_WR1: begin
        cmd.op     = OP_WR1;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        cmd.op     = OP_RD2;
        state_next = ST_WR2;
      end
      ST_WR2: begin
        cmd.op     = OP_WR2;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: rtl/core/pisf_dp.sv
module pisf_dp import pisf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  pisf_cmd_t   cmd,
  input  pisf_in_t    request,
  input  logic [31:0] gconst,
  input  logic [31:0] cconst,
  output pisf_out_t   result,
  output logic        done
);

  // load-time decode
  logic [32:0] dx_c, dy_c, ndx_c, ndy_c;
  logic [31:0] cv_c, av_c, bv_c, cm_c, am_c, bm_c;
  logic        an_c, bn_c, sneg_c;

  assign dx_c  = {request.second_x[31], request.second_x} - {request.first_x[31], request.first_x};
  assign dy_c  = {request.second_y[31], request.second_y} - {request.first_y[31], request.first_y};
  assign ndx_c = -dx_c;
  assign ndy_c = -dy_c;
  assign cv_c  = request.req_type ? cconst : gconst;
  assign av_c  = request.req_type ? request.first_charge : request.first_mass;
  assign bv_c  = request.req_type ? request.second_charge : request.second_mass;
  assign an_c  = request.req_type & av_c[31];
  assign bn_c  = request.req_type & bv_c[31];
  assign cm_c  = cv_c[31] ? -cv_c : cv_c;
  assign am_c  = an_c ? -av_c : av_c;
  assign bm_c  = bn_c ? -bv_c : bv_c;
  assign sneg_c = cv_c[31] ^ an_c ^ bn_c;

  logic [31:0]      ax, ay, cm, am, bm;
  logic             negx, negy, coin;
  logic [IDX_W-1:0] s1, s2;
  logic [65:0]      d2;
  logic [63:0]      ca, mbx, mby;
  logic [98:0]      den;
  logic [127:0]     nx, ny;

  // shared multiplier, one product per cycle, accumulated the cycle after
  logic [33:0] ma;
  logic [32:0] mb;
  logic [66:0] p;
  logic [3:0]  pstep;
  logic        pv;

  // sqrt and divider state
  logic [65:0]  sq_src;
  logic [34:0]  sq_rem;
  logic [32:0]  root;
  logic [36:0]  sq_t, sq_trial;
  logic [138:0] dvs;
  logic [127:0] remx, remy;
  logic [32:0]  qx, qy;
  logic         ovfx, ovfy;
  logic         gex, gey;

  assign sq_t     = {sq_rem, sq_src[65:64]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign gex      = {11'b0, remx} >= dvs;
  assign gey      = {11'b0, remy} >= dvs;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.step)
      MS_AXX: begin ma = 34'(ax); mb = 33'(ax); end
      MS_AYY: begin ma = 34'(ay); mb = 33'(ay); end
      MS_CA:  begin ma = 34'(cm); mb = 33'(am); end
      MS_MBX: begin ma = 34'(bm); mb = 33'(ax); end
      MS_MBY: begin ma = 34'(bm); mb = 33'(ay); end
      MS_DLO: begin ma = 34'(d2[31:0]); mb = root; end
      MS_DHI: begin ma = d2[65:32]; mb = root; end
      MS_NX0: begin ma = 34'(ca[31:0]);  mb = 33'(mbx[31:0]);  end
      MS_NX1: begin ma = 34'(ca[31:0]);  mb = 33'(mbx[63:32]); end
      MS_NX2: begin ma = 34'(ca[63:32]); mb = 33'(mbx[31:0]);  end
      MS_NX3: begin ma = 34'(ca[63:32]); mb = 33'(mbx[63:32]); end
      MS_NY0: begin ma = 34'(ca[31:0]);  mb = 33'(mby[31:0]);  end
      MS_NY1: begin ma = 34'(ca[31:0]);  mb = 33'(mby[63:32]); end
      MS_NY2: begin ma = 34'(ca[63:32]); mb = 33'(mby[31:0]);  end
      MS_NY3: begin ma = 34'(ca[63:32]); mb = 33'(mby[63:32]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= (cmd.op == OP_MUL);
    end
  end

  always_ff @(posedge clk) begin
    p     <= 67'(ma) * 67'(mb);
    pstep <= cmd.step;

    unique case (cmd.op)
      OP_LOAD: begin
        ax   <= dx_c[32] ? ndx_c[31:0] : dx_c[31:0];
        ay   <= dy_c[32] ? ndy_c[31:0] : dy_c[31:0];
        cm   <= cm_c;
        am   <= am_c;
        bm   <= bm_c;
        negx <= sneg_c ^ dx_c[32];
        negy <= sneg_c ^ dy_c[32];
        coin <= (dx_c == '0) && (dy_c == '0);
        s1   <= IDX_W'(32'(request.first_index) % PARTICLES);
        s2   <= IDX_W'(32'(request.second_index) % PARTICLES);
        d2   <= '0;
        den  <= '0;
        nx   <= '0;
        ny   <= '0;
      end
      OP_SQRT_INIT: begin
        sq_src <= d2;
        sq_rem <= '0;
        root   <= '0;
      end
      OP_SQRT_STEP: begin
        sq_src <= {sq_src[63:0], 2'b00};
        if (sq_t >= sq_trial) begin
          sq_rem <= 35'(sq_t - sq_trial);
          root   <= {root[31:0], 1'b1};
        end else begin
          sq_rem <= sq_t[34:0];
          root   <= {root[31:0], 1'b0};
        end
      end
      OP_DIV_INIT: begin
        remx <= nx;
        remy <= ny;
        dvs  <= {den, 40'b0};
        ovfx <= {12'b0, nx[127:41]} >= den;
        ovfy <= {12'b0, ny[127:41]} >= den;
        qx   <= '0;
        qy   <= '0;
      end
      OP_DIV_STEP: begin
        if (gex) begin
          remx <= remx - dvs[127:0];
        end
        if (gey) begin
          remy <= remy - dvs[127:0];
        end
        qx  <= {qx[31:0], gex};
        qy  <= {qy[31:0], gey};
        dvs <= {1'b0, dvs[138:1]};
      end
      default: ;
    endcase

    if (pv) begin
      case (pstep)
        MS_AXX, MS_AYY: d2 <= d2 + 66'(p);
        MS_CA:  ca  <= p[63:0];
        MS_MBX: mbx <= p[63:0];
        MS_MBY: mby <= p[63:0];
        MS_DLO: den <= den + 99'(p);
        MS_DHI: den <= den + 99'({p, 32'b0});
        MS_NX0: nx  <= nx + 128'(p);
        MS_NX1, MS_NX2: nx <= nx + 128'({p, 32'b0});
        MS_NX3: nx  <= nx + 128'({p, 64'b0});
        MS_NY0: ny  <= ny + 128'(p);
        MS_NY1, MS_NY2: ny <= ny + 128'({p, 32'b0});
        MS_NY3: ny  <= ny + 128'({p, 64'b0});
        default: ;
      endcase
    end
  end

  // component: clamp magnitude to 2^31, apply sign, clip positive side
  logic [31:0] mx, my, fx, fy;

  assign mx = (ovfx || qx > 33'h0_8000_0000) ? 32'h8000_0000 : qx[31:0];
  assign my = (ovfy || qy > 33'h0_8000_0000) ? 32'h8000_0000 : qy[31:0];

  always_comb begin
    if (coin) begin
      fx = '0;
      fy = '0;
    end else begin
      fx = negx ? -mx : (mx[31] ? 32'h7fff_ffff : mx);
      fy = negy ? -my : (my[31] ? 32'h7fff_ffff : my);
    end
  end

  // accumulator read-modify-write, first slot then second
  logic [IDX_W-1:0]     raddr, waddr;
  logic                 we;
  logic [31:0]          rdx, rdy, oldx, oldy, newx, newy, t1x, t1y;
  logic [PARTICLES-1:0] vld;
  logic                 vld_q;

  assign raddr = (cmd.op == OP_RD2) ? s2 : s1;
  assign waddr = (cmd.op == OP_WR1) ? s1 : s2;
  assign we    = (cmd.op == OP_WR1) || (cmd.op == OP_WR2);
  assign oldx  = vld_q ? rdx : '0;
  assign oldy  = vld_q ? rdy : '0;

  always_comb begin
    if (cmd.op == OP_WR1) begin
      newx = sat32({oldx[31], oldx} + {fx[31], fx});
      newy = sat32({oldy[31], oldy} + {fy[31], fy});
    end else begin
      newx = sat32({oldx[31], oldx} - {fx[31], fx});
      newy = sat32({oldy[31], oldy} - {fy[31], fy});
    end
  end

  pisf_ram #(.WIDTH(32), .DEPTH(PARTICLES)) u_ram_x (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (newx),
    .raddr (raddr),
    .rdata (rdx)
  );

  pisf_ram #(.WIDTH(32), .DEPTH(PARTICLES)) u_ram_y (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (newy),
    .raddr (raddr),
    .rdata (rdy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      done <= (cmd.op == OP_WR2);
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= vld[raddr];
    if (cmd.op == OP_WR1) begin
      t1x <= newx;
      t1y <= newy;
    end
    if (cmd.op == OP_WR2) begin
      result.pair_force_x   <= fx;
      result.pair_force_y   <= fy;
      result.first_total_x  <= (s1 == s2) ? newx : t1x;
      result.first_total_y  <= (s1 == s2) ? newy : t1y;
      result.second_total_x <= newx;
      result.second_total_y <= newy;
      result.coincident     <= coin;
    end
  end

endmodule

// File: rtl/core/pairwise_inverse_square_force.sv
// A new item is taken only while idle, so items never overlap; the next start
// is taken in the done cycle. Each item runs the 33-step sqrt, the 33-step
// divider and 15 products on one multiplier. The result is on result for the
// single cycle done is high; it cannot be stalled.
// Synchronous reset clears the constants and every accumulator slot at once.
module pairwise_inverse_square_force import pisf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pisf_in_t    request,
  output pisf_out_t   result,
  output logic        done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_GRAVITY = 1'b0;
  localparam logic REG_COULOMB = 1'b1;

  logic [31:0] gconst, cconst;
  pisf_cmd_t   cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gconst <= '0;
      cconst <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_GRAVITY: gconst <= pwdata;
        REG_COULOMB: cconst <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRAVITY: prdata = gconst;
      REG_COULOMB: prdata = cconst;
      default:     prdata = '0;
    endcase
  end

  pisf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  pisf_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .gconst  (gconst),
    .cconst  (cconst),
    .result  (result),
    .done    (done)
  );

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while still busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for more than one cycle");
`endif

endmodule
